// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the merge sort engine.
// Depends on nothing; each macro takes the clock and the active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant violated");

// When the antecedent holds, the consequent holds in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

// When the antecedent holds, the consequent holds in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

// ===== sv/mse_pkg.sv =====
// Shared types and constants of the merge sort engine.
// Depends on nothing; used by the channel interfaces and the top level.
package mse_pkg;

    localparam int DATA_W = 32;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        S_IDLE    = 9'b0_0000_0001,
        S_BLOCK   = 9'b0_0000_0010,
        S_RDA     = 9'b0_0000_0100,
        S_RDB     = 9'b0_0000_1000,
        S_MERGE   = 9'b0_0001_0000,
        S_FILLA   = 9'b0_0010_0000,
        S_FILLB   = 9'b0_0100_0000,
        S_EMIT_RD = 9'b0_1000_0000,
        S_EMIT_WR = 9'b1_0000_0000
    } state_t;

endpackage

// ===== sv/mse_ifs.sv =====
// Valid/ready channel interfaces for the input items and the sorted results.
// Depends on mse_pkg for the data width.
interface mse_item_if;
    import mse_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value;
    logic                     is_last;

    modport source (output valid, value, is_last, input ready);
    modport sink (input valid, value, is_last, output ready);
endinterface

interface mse_result_if;
    import mse_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     is_final;
    logic                     dropped;

    modport source (output valid, sorted_value, is_final, dropped, input ready);
    modport sink (input valid, sorted_value, is_final, dropped, output ready);
endinterface

// ===== sv/merge_sort_engine.sv =====
// Top level of the merge sort engine: load counter, merge sequencer, output register.
// Depends on mse_pkg, mse_ifs (channels), mse_ram and assert_macros.svh.
//
// Usage: items (sink) takes one signed 32-bit value per request; is_last ends a
// data set. Up to MAX_ITEMS values are stored; further values of the set are
// discarded and every result of that set then carries dropped = 1.
// Loading accepts one request per cycle. On the last request the block drops
// ready and sorts the stored values by a bottom-up stable merge that alternates
// between two RAMs, with one comparator and one read port per RAM. In each of the
// ceil(log2(n)) passes, each run pair starts with a block setup step and the reads
// of its first left and right elements; every merged element then takes a
// compare/write step and a refill read, but the last element of a pair needs none.
// The n results then leave on results (source), each read back before it is staged, in
// ascending order, the last one with is_final = 1. A set of one item skips the
// merge; a set that stores nothing gives no results.
// A result sits in an output register; a stalled receiver holds the sequencer
// in its emit step, and ready on items returns as soon as the last result is
// staged. Reset clears the count, the overflow flag and the output valid; the
// RAM contents are not cleared, and only values that have been written are used.
`include "assert_macros.svh"

module merge_sort_engine #(
    parameter int MAX_ITEMS = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    mse_item_if.sink     items,
    mse_result_if.source results
);
    import mse_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] ONE = CW'(1);

    state_t state_reg, state_next;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          par_reg, par_next;
    logic [CW-1:0] w_reg, w_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] e_reg, e_next;

    logic signed [DATA_W-1:0] a_reg, a_next;
    logic signed [DATA_W-1:0] b_reg, b_next;

    logic                     ov_valid_reg, ov_valid_next;
    logic signed [DATA_W-1:0] ov_value_reg, ov_value_next;
    logic                     ov_final_reg, ov_final_next;
    logic                     ov_drop_reg, ov_drop_next;

    logic              wr_en_a, wr_en_b;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] rd_data_a, rd_data_b;
    logic signed [DATA_W-1:0] src_data;

    logic [SW-1:0] n_ext, lo_w, lo_2w, w_2;
    logic [CW-1:0] mid_calc, hi_calc;
    logic [CW-1:0] cnt_after;
    logic          a_ok, b_ok, take_a, out_free;
    logic          merge_in_range;

    mse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_store_a (
        .clk     (clk),
        .wr_en   (wr_en_a),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data_a)
    );

    mse_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_store_b (
        .clk     (clk),
        .wr_en   (wr_en_b),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data_b)
    );

    // The parity bit names the store that holds the current source runs.
    assign src_data = $signed(par_reg ? rd_data_b : rd_data_a);

    assign n_ext    = {2'b00, count_reg};
    assign lo_w     = {2'b00, lo_reg} + {2'b00, w_reg};
    assign w_2      = {2'b00, w_reg} << 1;
    assign lo_2w    = {2'b00, lo_reg} + w_2;
    assign mid_calc = (lo_w > n_ext) ? count_reg : lo_w[CW-1:0];
    assign hi_calc  = (lo_2w > n_ext) ? count_reg : lo_2w[CW-1:0];
    assign cnt_after = (count_reg < MAX_CNT) ? (count_reg + ONE) : count_reg;

    // Equal keys take the left run first, which keeps the sort stable.
    assign a_ok   = (i_reg < mid_reg);
    assign b_ok   = (j_reg < hi_reg);
    assign take_a = a_ok && (!b_ok || (a_reg <= b_reg));

    assign merge_in_range = (i_reg <= mid_reg) && (j_reg <= hi_reg) && (k_reg < hi_reg);

    assign out_free    = !ov_valid_reg || results.ready;
    assign items.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        par_next      = par_reg;
        w_next        = w_reg;
        lo_next       = lo_reg;
        mid_next      = mid_reg;
        hi_next       = hi_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        e_next        = e_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        ov_valid_next = ov_valid_reg && !results.ready;
        ov_value_next = ov_value_reg;
        ov_final_next = ov_final_reg;
        ov_drop_next  = ov_drop_reg;
        wr_en_a       = 1'b0;
        wr_en_b       = 1'b0;
        wr_addr       = k_reg[AW-1:0];
        wr_data       = (take_a ? a_reg : b_reg);
        rd_addr       = e_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                wr_addr = count_reg[AW-1:0];
                wr_data = items.value;
                if (items.valid)
                begin
                    if (count_reg < MAX_CNT)
                    begin
                        wr_en_a = 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    count_next = cnt_after;
                    if (items.is_last)
                    begin
                        par_next = 1'b0;
                        if (cnt_after == '0)
                        begin
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        else if (cnt_after == ONE)
                        begin
                            e_next     = '0;
                            state_next = S_EMIT_RD;
                        end
                        else
                        begin
                            w_next     = ONE;
                            lo_next    = '0;
                            state_next = S_BLOCK;
                        end
                    end
                end
            end
            S_BLOCK:
            begin
                mid_next   = mid_calc;
                hi_next    = hi_calc;
                i_next     = lo_reg;
                j_next     = mid_calc;
                k_next     = lo_reg;
                rd_addr    = lo_reg[AW-1:0];
                state_next = S_RDA;
            end
            S_RDA:
            begin
                a_next     = src_data;
                rd_addr    = j_reg[AW-1:0];
                state_next = S_RDB;
            end
            S_RDB:
            begin
                b_next     = src_data;
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                wr_en_a = par_reg;
                wr_en_b = !par_reg;
                k_next  = k_reg + ONE;
                if (take_a)
                begin
                    i_next     = i_reg + ONE;
                    rd_addr    = i_next[AW-1:0];
                    state_next = S_FILLA;
                end
                else
                begin
                    j_next     = j_reg + ONE;
                    rd_addr    = j_next[AW-1:0];
                    state_next = S_FILLB;
                end
                if (k_next == hi_reg)
                begin
                    if (lo_2w >= n_ext)
                    begin
                        par_next = !par_reg;
                        if (w_2 >= n_ext)
                        begin
                            e_next     = '0;
                            state_next = S_EMIT_RD;
                        end
                        else
                        begin
                            w_next     = w_2[CW-1:0];
                            lo_next    = '0;
                            state_next = S_BLOCK;
                        end
                    end
                    else
                    begin
                        lo_next    = lo_2w[CW-1:0];
                        state_next = S_BLOCK;
                    end
                end
            end
            S_FILLA:
            begin
                a_next     = src_data;
                state_next = S_MERGE;
            end
            S_FILLB:
            begin
                b_next     = src_data;
                state_next = S_MERGE;
            end
            S_EMIT_RD:
            begin
                state_next = S_EMIT_WR;
            end
            S_EMIT_WR:
            begin
                // The read address is held, so the RAM output stays valid while stalled.
                if (out_free)
                begin
                    ov_valid_next = 1'b1;
                    ov_value_next = src_data;
                    ov_final_next = ((e_reg + ONE) == count_reg);
                    ov_drop_next  = ovf_reg;
                    e_next        = e_reg + ONE;
                    if ((e_reg + ONE) == count_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            ov_valid_reg <= ov_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        par_reg      <= par_next;
        w_reg        <= w_next;
        lo_reg       <= lo_next;
        mid_reg      <= mid_next;
        hi_reg       <= hi_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        e_reg        <= e_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        ov_value_reg <= ov_value_next;
        ov_final_reg <= ov_final_next;
        ov_drop_reg  <= ov_drop_next;
    end

    assign results.valid        = ov_valid_reg;
    assign results.sorted_value = ov_value_reg;
    assign results.is_final     = ov_final_reg;
    assign results.dropped      = ov_drop_reg;

    `ASSERT_ALWAYS(a_count_cap, clk, rst_n, count_reg <= MAX_CNT)
    `ASSERT_IMPLIES(a_merge_bounds, clk, rst_n, state_reg == S_MERGE, merge_in_range)
    `ASSERT_NEXT(a_emit_stage, clk, rst_n, (state_reg == S_EMIT_WR) && out_free, results.valid)

endmodule

// ===== sv/mse_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule
